/* design/bcr_pkg.sv */
// Shared types and constants for the GF(2) boundary column reduction unit.
package bcr_pkg;

    localparam int C_ROWS   = 64;
    localparam int C_ROW_W  = 6;
    localparam int C_IDX_W  = 6;
    localparam int C_OUT_W  = 144;

    typedef logic [C_ROWS-1:0]  t_mask;
    typedef logic [C_ROW_W-1:0] t_row;

    typedef struct packed {
        logic nz;
        t_row row;
    } t_lead;

    typedef struct packed {
        t_mask rep;
        t_mask red;
    } t_col;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_XOR  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

/* design/boundary_column_reduction_gf2_unit.sv */
// Flow: S_IDLE takes a column, S_SCAN and S_XOR perform k additions (k <= 63), and S_DONE
// registers the result; an overflowed column goes from S_IDLE straight to S_DONE. One column
// in flight; each addition is a store read in S_SCAN followed by an XOR in S_XOR.
// A new column is accepted only in S_IDLE; S_DONE holds while the output register is full and not taken.
// Reset: synchronous active-low; clears pivot valid bits, column count and handshakes.
// Column store contents are left undefined; entries are only read behind a valid bit.
module boundary_column_reduction_gf2_unit #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  bcr_pkg::t_mask                 i_s_tdata,  // [63:0] boundary_bits
    input  logic                           i_s_tuser,  // [0] start_req
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [5:0] column_index, [69:6] reduced_bits, [133:70] representative_bits,
    // [139:134] pivot_row, [140] has_pivot, [143:141] zero
    output logic [bcr_pkg::C_OUT_W-1:0]    o_m_tdata,
    output logic                           o_m_tuser   // [0] overflow
);
    import bcr_pkg::*;

    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [C_ROWS-1:0]   r_owned, n_owned;
    t_mask               r_red, n_red;
    t_mask               r_rep, n_rep;
    logic [C_IDX_W-1:0]  r_col, n_col;
    t_row                r_piv, n_piv;
    logic                r_hp, n_hp;
    logic                r_ovf, n_ovf;
    t_row                r_scan_row, n_scan_row;
    logic                r_m_tvalid, n_m_tvalid;
    logic [C_OUT_W-1:0]  r_m_tdata, n_m_tdata;
    logic                r_m_tuser, n_m_tuser;

    logic [CNT_W-1:0]    cnt_eff;
    t_lead               lead;
    logic                mem_wr, mem_rd;
    t_col                mem_wdata, mem_rdata;

    bcr_lead_enc u_lead (
        .i_mask (r_red),
        .o_lead (lead)
    );

    assign mem_wdata = '{rep: r_rep, red: r_red};

    bcr_col_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (lead.row),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_rd),
        .i_rd_addr (lead.row),
        .o_rd_data (mem_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign cnt_eff    = i_s_tuser ? '0 : r_count;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_owned    = r_owned;
        n_red      = r_red;
        n_rep      = r_rep;
        n_col      = r_col;
        n_piv      = r_piv;
        n_hp       = r_hp;
        n_ovf      = r_ovf;
        n_scan_row = r_scan_row;
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;
        mem_wr     = 1'b0;
        mem_rd     = 1'b0;

        if (r_m_tvalid && i_m_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser) begin
                        n_owned = '0;
                    end
                    n_count = cnt_eff;
                    n_col   = C_IDX_W'(cnt_eff);
                    n_red   = i_s_tdata;
                    n_rep   = t_mask'(1) << C_IDX_W'(cnt_eff);
                    n_hp    = 1'b0;
                    n_piv   = '0;
                    if (cnt_eff >= CNT_W'(MAX_COLUMNS)) begin
                        n_ovf   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_ovf   = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (lead.nz && r_owned[lead.row]) begin
                    mem_rd     = 1'b1;
                    n_scan_row = lead.row;
                    n_state    = S_XOR;
                end else begin
                    if (lead.nz) begin
                        mem_wr                = 1'b1;
                        n_owned[lead.row]     = 1'b1;
                    end
                    n_piv   = lead.row;
                    n_hp    = lead.nz;
                    n_count = r_count + CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_XOR: begin
                n_red   = r_red ^ mem_rdata.red;
                n_rep   = r_rep ^ mem_rdata.rep;
                n_state = S_SCAN;
            end
            S_DONE: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tuser  = r_ovf;
                    if (r_ovf) begin
                        n_m_tdata = '0;
                    end else begin
                        n_m_tdata = {3'b000, r_hp, r_piv, r_rep, r_red, r_col};
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_owned    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_owned    <= n_owned;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red      <= n_red;
        r_rep      <= n_rep;
        r_col      <= n_col;
        r_piv      <= n_piv;
        r_hp       <= n_hp;
        r_ovf      <= n_ovf;
        r_scan_row <= n_scan_row;
        r_m_tdata  <= n_m_tdata;
        r_m_tuser  <= n_m_tuser;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

`ifndef SYNTHESIS
    a_pivot_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XOR) |=> !r_red[$past(r_scan_row)])
        else $error("eliminated pivot row still set after addition");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_COLUMNS))
        else $error("column count beyond capacity");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("overflow result carries data");

    a_empty_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[140]) |->
        ((o_m_tdata[69:6] == '0) && (o_m_tdata[139:134] == '0)))
        else $error("column without pivot is not empty");
`endif

endmodule

/* design/bcr_lead_enc.sv */
// Highest-set-row detector for a column mask.
module bcr_lead_enc (
    input  bcr_pkg::t_mask i_mask,
    output bcr_pkg::t_lead o_lead
);
    import bcr_pkg::*;

    always_comb begin
        o_lead.nz  = |i_mask;
        o_lead.row = '0;
        for (int i = 0; i < C_ROWS; i++) begin
            if (i_mask[i]) begin
                o_lead.row = C_ROW_W'(i);
            end
        end
    end

endmodule

/* design/bcr_col_mem.sv */
// Reduced column and representative store, addressed by pivot row.
module bcr_col_mem (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  bcr_pkg::t_row   i_wr_addr,
    input  bcr_pkg::t_col   i_wr_data,
    input  logic            i_rd_en,
    input  bcr_pkg::t_row   i_rd_addr,
    output bcr_pkg::t_col   o_rd_data
);
    import bcr_pkg::*;

    t_col r_mem [C_ROWS];
    t_col r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
